FILE: rtl/rqkr_pkg.sv
// Shared types and codes for the ready queue with keyed removal.
package rqkr_pkg;

    // Operation codes carried by a request
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_FIND   = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_EXEC,
        S_OUT
    } t_state;

    // Width of the reported entry count
    localparam int COUNT_W = 5;

    // Compare command broadcast to every cell
    typedef struct packed {
        logic cmp_en;      // capture a match flag this cycle
        logic cmp_handle;  // compare handle (push) instead of ID
    } t_cell_cmd;

endpackage

FILE: rtl/rqkr_cell.sv
// One queue slot: holds a handle and an ID, matches against the key, shifts toward the head.
module rqkr_cell
    import rqkr_pkg::*;
#(
    parameter int HW = 16,
    parameter int IW = 16
) (
    input  logic          i_clk,
    input  t_cell_cmd     i_cmd,
    input  logic          i_valid,
    input  logic [HW-1:0] i_key_handle,
    input  logic [IW-1:0] i_key_id,
    input  logic          i_load,
    input  logic          i_shift,
    input  logic [HW-1:0] i_nb_handle,
    input  logic [IW-1:0] i_nb_id,
    output logic [HW-1:0] o_handle,
    output logic [IW-1:0] o_id,
    output logic          o_hit
);

    logic [HW-1:0] r_handle;
    logic [IW-1:0] r_id;
    logic          r_hit;

    // Slot contents: load a new entry or take the neighbor's entry
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_handle <= i_key_handle;
            r_id     <= i_key_id;
        end else if (i_shift) begin
            r_handle <= i_nb_handle;
            r_id     <= i_nb_id;
        end
    end

    // Match flag, only for occupied slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en) begin
            if (i_cmd.cmp_handle) begin
                r_hit <= i_valid && (r_handle == i_key_handle);
            end else begin
                r_hit <= i_valid && (r_id == i_key_id);
            end
        end
    end

    assign o_handle = r_handle;
    assign o_id     = r_id;
    assign o_hit    = r_hit;

endmodule

FILE: rtl/ready_queue_with_keyed_removal.sv
// Top level of the ready queue with keyed removal: sequencer and row of slot cells.
//
// Ordered task queue of QUEUE_DEPTH slots built as a row of cells, the head in cell 0.
// Each request (push, pop, find by ID, remove by ID) gives one result with the handle,
// a status and the new entry count. One request is in work at a time. The result is
// offered from the result register after key compare in every cell, pick of the oldest
// match and update of the row, and holds there while the consumer stalls. A new request
// is taken in the cycle after the result leaves. Removal closes the gap by shifting every
// cell behind the removed entry one place toward the head, all together. No clearing
// pass is needed after reset.
module ready_queue_with_keyed_removal
    import rqkr_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 16,
    parameter int HANDLE_WIDTH = 16,
    parameter int ID_WIDTH     = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_operation,
    input  logic [HANDLE_WIDTH-1:0]            i_task_handle,
    input  logic [ID_WIDTH-1:0]                i_task_id,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [HANDLE_WIDTH-1:0]            o_out_handle,
    output logic [1:0]                         o_status,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_entry_count
);

    localparam int N  = QUEUE_DEPTH;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state                  r_state, n_state;
    t_op                     r_op;
    logic [HANDLE_WIDTH-1:0] r_key_h;
    logic [ID_WIDTH-1:0]     r_key_id;
    logic [CW-1:0]           r_count, n_count;
    logic [N-1:0]            r_first, n_first;
    logic                    r_found, n_found;
    logic [HANDLE_WIDTH-1:0] r_out_h, n_out_h;
    t_status                 r_out_st, n_out_st;

    t_cell_cmd               w_cmd;
    logic [N-1:0]            w_valid, w_hit, w_load, w_shift;
    logic [HANDLE_WIDTH-1:0] w_h  [N];
    logic [ID_WIDTH-1:0]     w_id [N];
    logic [HANDLE_WIDTH-1:0] w_sel_h;
    logic [N-1:0]            w_ge_mask;
    logic                    w_accept;

    assign w_accept = i_valid && o_ready;

    // Row of slot cells, each but the last fed by its neighbor toward the tail
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [HANDLE_WIDTH-1:0] nb_h;
        logic [ID_WIDTH-1:0]     nb_id;

        assign w_valid[g] = CW'(g) < r_count;

        if (g == N - 1) begin : g_tail
            assign nb_h  = w_h[g];
            assign nb_id = w_id[g];
        end else begin : g_mid
            assign nb_h  = w_h[g+1];
            assign nb_id = w_id[g+1];
        end

        rqkr_cell #(
            .HW(HANDLE_WIDTH),
            .IW(ID_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_valid     (w_valid[g]),
            .i_key_handle(r_key_h),
            .i_key_id    (r_key_id),
            .i_load      (w_load[g]),
            .i_shift     (w_shift[g]),
            .i_nb_handle (nb_h),
            .i_nb_id     (nb_id),
            .o_handle    (w_h[g]),
            .o_id        (w_id[g]),
            .o_hit       (w_hit[g])
        );
    end

    // Handle of the selected cell: AND-OR over the one-hot pick
    always_comb begin
        w_sel_h = '0;
        for (int i = 0; i < N; i++) begin
            w_sel_h = w_sel_h | (w_h[i] & {HANDLE_WIDTH{r_first[i]}});
        end
    end

    // Cells at or behind the picked one
    assign w_ge_mask = ~(r_first - N'(1));

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= t_op'(i_operation);
            r_key_h  <= i_task_handle;
            r_key_id <= i_task_id;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Pick and result registers
    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_found  <= n_found;
        r_out_h  <= n_out_h;
        r_out_st <= n_out_st;
    end

    // Sequencer: next state, cell commands, result
    always_comb begin
        n_state          = r_state;
        n_count          = r_count;
        n_first          = r_first;
        n_found          = r_found;
        n_out_h          = r_out_h;
        n_out_st         = r_out_st;
        w_cmd.cmp_en     = 1'b0;
        w_cmd.cmp_handle = (r_op == OP_PUSH);
        w_load           = '0;
        w_shift          = '0;
        o_ready          = 1'b0;
        o_valid          = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_cmd.cmp_en = 1'b1;
                n_state      = S_SEL;
            end
            S_SEL: begin
                if (r_op == OP_POP) begin
                    n_found = (r_count != '0);
                    n_first = {{(N-1){1'b0}}, n_found};
                end else begin
                    n_found = |w_hit;
                    n_first = w_hit & (~w_hit + N'(1));
                end
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_out_h  = '0;
                n_out_st = ST_OK;
                case (r_op)
                    OP_PUSH: begin
                        if (r_found) begin
                            n_out_st = ST_DUP;
                        end else if (r_count == CW'(N)) begin
                            n_out_st = ST_FULL;
                        end else begin
                            w_load  = N'(1) << r_count;
                            n_count = r_count + CW'(1);
                        end
                    end
                    OP_POP, OP_REMOVE: begin
                        if (r_found) begin
                            n_out_h = w_sel_h;
                            w_shift = w_ge_mask;
                            n_count = r_count - CW'(1);
                        end else begin
                            n_out_st = ST_NONE;
                        end
                    end
                    OP_FIND: begin
                        if (r_found) begin
                            n_out_h = w_sel_h;
                        end else begin
                            n_out_st = ST_NONE;
                        end
                    end
                    default: begin
                        n_out_st = ST_NONE;
                    end
                endcase
                n_state = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_handle  = r_out_h;
    assign o_status      = r_out_st;
    assign o_entry_count = r_count;

endmodule

FILE: verif/tb_ready_queue_with_keyed_removal.sv
// Self-checking testbench for the ready queue with keyed removal.
`timescale 1ns / 1ps

module tb_ready_queue_with_keyed_removal;
    import rqkr_pkg::*;

    localparam int DEPTH         = 16;
    localparam int HW            = 16;
    localparam int IW            = 16;
    localparam int RANDOM_REQS   = 1025;
    localparam int QUIET_TAIL    = 120;     // last requests run with no idling
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HANDLE_POOL   = 24;      // more handles than slots, so the queue can fill
    localparam int ID_POOL       = 6;       // few keys, so find and remove often hit

    typedef struct {
        t_op           op;
        logic [HW-1:0] handle;
        logic [IW-1:0] id;
        bit            pause;   // hold off until every result is back
    } t_queue_req;

    typedef struct {
        logic [HW-1:0]      handle;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_queue_resp;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_operation = '0;
    logic [HW-1:0]      i_task_handle = '0;
    logic [IW-1:0]      i_task_id = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [HW-1:0]      o_out_handle;
    logic [1:0]         o_status;
    logic [COUNT_W-1:0] o_entry_count;

    t_queue_req  request_backlog[$];
    t_queue_resp due_results[$];

    // Shadow copy of the queue contents, head at index 0
    logic [HW-1:0] shadow_handles[DEPTH];
    logic [IW-1:0] shadow_ids[DEPTH];
    int            shadow_count = 0;

    int cycle_count   = 0;
    int fail_count    = 0;
    int total_reqs    = 0;
    int accepted_reqs = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int max_depth_seen = 0;
    int send_gap  = 0;
    int recv_stall = 0;

    ready_queue_with_keyed_removal #(
        .QUEUE_DEPTH (DEPTH),
        .HANDLE_WIDTH(HW),
        .ID_WIDTH    (IW)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_task_handle(i_task_handle),
        .i_task_id    (i_task_id),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_handle (o_out_handle),
        .o_status     (o_status),
        .o_entry_count(o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Take the entry at pos out and close the gap toward the head
    function automatic void unlink_entry(input int pos);
        for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_handles[i] = shadow_handles[i + 1];
            shadow_ids[i]     = shadow_ids[i + 1];
        end
        shadow_count--;
    endfunction

    // Apply one request to the shadow queue and give the response it must produce
    function automatic t_queue_resp apply_queue_op(input t_queue_req req);
        t_queue_resp resp;
        resp.handle = '0;
        resp.status = ST_OK;
        case (req.op)
            OP_PUSH: begin
                bit dup;
                dup = 1'b0;
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_handles[i] == req.handle) dup = 1'b1;
                // duplicate check wins over the full check
                if (dup) begin
                    resp.status = ST_DUP;
                end else if (shadow_count >= DEPTH) begin
                    resp.status = ST_FULL;
                end else begin
                    shadow_handles[shadow_count] = req.handle;
                    shadow_ids[shadow_count]     = req.id;
                    shadow_count++;
                end
            end
            OP_POP: begin
                if (shadow_count == 0) begin
                    resp.status = ST_NONE;
                end else begin
                    resp.handle = shadow_handles[0];
                    unlink_entry(0);
                end
            end
            default: begin
                int pos;
                pos = shadow_count;
                // oldest entry with a matching ID
                for (int i = shadow_count - 1; i >= 0; i--)
                    if (shadow_ids[i] == req.id) pos = i;
                if (pos == shadow_count) begin
                    resp.status = ST_NONE;
                end else begin
                    resp.handle = shadow_handles[pos];
                    if (req.op == OP_REMOVE) unlink_entry(pos);
                end
            end
        endcase
        resp.count = shadow_count[COUNT_W-1:0];
        return resp;
    endfunction

    function automatic void add_req(input t_op op, input logic [HW-1:0] h,
                                    input logic [IW-1:0] id);
        t_queue_req req;
        req.op     = op;
        req.handle = h;
        req.id     = id;
        req.pause  = 1'b0;
        request_backlog.push_back(req);
        total_reqs++;
    endfunction

    function automatic void add_pause();
        t_queue_req req;
        req.op     = OP_PUSH;
        req.handle = '0;
        req.id     = '0;
        req.pause  = 1'b1;
        request_backlog.push_back(req);
    endfunction

    // Idling is off in the tail of the run and in a recurring calm window
    function automatic bit idling_allowed();
        return (request_backlog.size() > QUIET_TAIL) && ((cycle_count % 512) < 400);
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        bit         next_valid;
        t_queue_req req;
        next_valid = i_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!i_valid || o_ready) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (request_backlog.size() != 0) begin
                if (request_backlog[0].pause) begin
                    // only leave the pause once nothing is outstanding
                    if (!i_valid && due_results.size() == 0)
                        void'(request_backlog.pop_front());
                end else if (idling_allowed() && $urandom_range(0, 6) == 0) begin
                    send_gap = $urandom_range(1, 10) - 1;
                end else begin
                    req = request_backlog.pop_front();
                    next_valid = 1'b1;
                    i_operation   <= req.op;
                    i_task_handle <= req.handle;
                    i_task_id     <= req.id;
                end
            end
        end
        i_valid <= next_valid;
    end

    // Response receiver: random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            i_ready <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
            recv_stall = $urandom_range(1, 10) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: check each response, then predict each accepted request
    always @(posedge i_clk) begin
        t_queue_resp exp_resp;
        t_queue_req  req;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (due_results.size() == 0) begin
                    $error("response with none outstanding: handle %h status %0d count %0d",
                           o_out_handle, o_status, o_entry_count);
                    fail_count++;
                end else begin
                    exp_resp = due_results.pop_front();
                    status_seen[exp_resp.status]++;
                    if (o_out_handle !== exp_resp.handle) begin
                        $error("out_handle mismatch: expected %h, actual %h",
                               exp_resp.handle, o_out_handle);
                        fail_count++;
                    end
                    if (o_status !== exp_resp.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_resp.status, o_status);
                        fail_count++;
                    end
                    if (o_entry_count !== exp_resp.count) begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               exp_resp.count, o_entry_count);
                        fail_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                req.op     = t_op'(i_operation);
                req.handle = i_task_handle;
                req.id     = i_task_id;
                req.pause  = 1'b0;
                due_results.push_back(apply_queue_op(req));
                if (shadow_count > max_depth_seen) max_depth_seen = shadow_count;
                accepted_reqs++;
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        logic [HW-1:0] handle_set[HANDLE_POOL];
        logic [IW-1:0] id_set[ID_POOL];
        logic [HW-1:0] h;
        logic [IW-1:0] id;
        int            mix;
        int            r;

        // Empty queue: pop, find and remove all miss
        add_req(OP_POP,    16'h1234, 16'h0000);
        add_req(OP_FIND,   16'h0000, 16'h0000);
        add_req(OP_REMOVE, 16'hFFFF, 16'hFFFF);
        // Fill to capacity; handle and ID extremes at the ends, shared IDs in between
        for (int k = 0; k < DEPTH; k++) begin
            h  = (k == 0) ? 16'h0000 : (k == DEPTH - 1) ? 16'hFFFF : 16'h1000 + 16'(k);
            id = (k == 0) ? 16'h0000 : (k == DEPTH - 1) ? 16'hFFFF
                                                        : 16'hA5A0 + 16'(k % 3);
            add_req(OP_PUSH, h, id);
        end
        add_req(OP_PUSH,   16'hBEEF, 16'h0001);   // full queue drops it
        add_req(OP_PUSH,   16'h0000, 16'h0002);   // duplicate flagged even when full
        add_req(OP_FIND,   16'h0000, 16'hA5A1);   // several matches: oldest one
        add_req(OP_REMOVE, 16'h0000, 16'hA5A2);   // unlink from the middle
        add_req(OP_POP,    16'h0000, 16'h0000);
        add_req(OP_REMOVE, 16'h0000, 16'hFFFF);   // unlink the tail
        add_pause();

        for (int k = 0; k < HANDLE_POOL; k++) handle_set[k] = 16'($urandom);
        for (int k = 0; k < ID_POOL; k++) id_set[k] = 16'($urandom);
        handle_set[0] = '0;
        handle_set[HANDLE_POOL-1] = '1;
        id_set[0] = '0;
        id_set[ID_POOL-1] = '1;

        // Random requests in phases that lean toward filling, draining or neither
        mix = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 80 == 0) mix = $urandom_range(0, 2);
            if (n == RANDOM_REQS / 2) add_pause();
            h  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                             : handle_set[$urandom_range(0, HANDLE_POOL-1)];
            id = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                             : id_set[$urandom_range(0, ID_POOL-1)];
            r = $urandom_range(0, 99);
            case (mix)
                0:       r = (r < 65) ? 0 : (r < 75) ? 1 : (r < 88) ? 2 : 3;
                1:       r = (r < 25) ? 0 : (r < 50) ? 1 : (r < 70) ? 2 : 3;
                default: r = (r < 40) ? 0 : (r < 60) ? 1 : (r < 80) ? 2 : 3;
            endcase
            add_req(t_op'(r[1:0]), h, id);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_reqs < total_reqs) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests in %0d cycles, peak depth %0d of %0d.",
                 accepted_reqs, cycle_count, max_depth_seen, DEPTH);
        $display("Responses: ok %0d, empty or no match %0d, duplicate %0d, full %0d.",
                 status_seen[ST_OK], status_seen[ST_NONE], status_seen[ST_DUP],
                 status_seen[ST_FULL]);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
